### src/b32sc_pkg.sv
// Shared types, constants and alphabet helpers for the Base32 stream codec.
`timescale 1ns / 1ps
package b32sc_pkg;

	localparam int unsigned DataW   = 8;
	localparam int unsigned SymW    = 5;
	localparam int unsigned BufW    = 12;
	localparam int unsigned CntW    = 4;
	localparam int unsigned MaxRes  = 3;
	localparam int unsigned QDepth  = 4;
	localparam int unsigned QPtrW   = 2;
	localparam int unsigned QCntW   = 3;

	localparam logic [SymW-1:0]  SymMask    = 5'h1F;
	localparam logic [SymW-1:0]  NumLetters = 5'd26;
	localparam logic [DataW-1:0] CharA      = 8'h41;
	localparam logic [DataW-1:0] CharZ      = 8'h5A;
	localparam logic [DataW-1:0] Char2      = 8'h32;
	localparam logic [DataW-1:0] Char7      = 8'h37;

	localparam logic DirEncode = 1'b0;
	localparam logic DirDecode = 1'b1;

	// One classified input item: the words it yields, ready to be played out.
	typedef struct packed {
		logic [MaxRes-1:0][DataW-1:0] vals;
		logic [1:0]                   num;   // 1..3 words
		logic                         eos;
		logic                         bad;
	} job_t;

	function automatic logic [DataW-1:0] sym_to_char(input logic [SymW-1:0] v);
		logic [SymW-1:0] s;
		s = v & SymMask;
		if (s < NumLetters) begin
			sym_to_char = CharA + {3'b000, s};
		end else begin
			sym_to_char = Char2 + {3'b000, s - NumLetters};
		end
	endfunction

	function automatic logic [SymW:0] char_to_sym(input logic [DataW-1:0] c);
		// returns {bad, symbol}
		if (c inside {[CharA:CharZ]}) begin
			char_to_sym = {1'b0, SymW'(c - CharA)};
		end else if (c inside {[Char2:Char7]}) begin
			char_to_sym = {1'b0, SymW'(c - Char2) + NumLetters};
		end else begin
			char_to_sym = {1'b1, {SymW{1'b0}}};
		end
	endfunction

endpackage

### src/b32sc_front.sv
// Front end: accepts input words, keeps the bit accumulator and builds jobs.
`timescale 1ns / 1ps
module b32sc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	input  logic                          in_valid,
	input  logic [b32sc_pkg::DataW-1:0]   data_in,
	input  logic                          end_of_stream,
	output logic                          job_push,
	output b32sc_pkg::job_t               job
);
	import b32sc_pkg::*;

	logic            direction_q;
	logic [BufW-1:0] buf_q;
	logic [CntW-1:0] cnt_q;

	logic [SymW:0]   dec_sym;
	logic [19:0]     enc_ins;
	logic [19:0]     dec_ins;
	logic [BufW-1:0] enc_buf;
	logic [BufW-1:0] dec_buf;
	logic [4:0]      enc_sum;
	logic [4:0]      dec_sum;
	logic            enc_two;
	logic [4:0]      enc_rem;
	logic [BufW-1:0] enc_left;

	logic [BufW-1:0] nxt_buf;
	logic [CntW-1:0] nxt_cnt;

	assign dec_sym  = char_to_sym(data_in);
	assign enc_ins  = {12'b0, data_in} << cnt_q;
	assign dec_ins  = {15'b0, dec_sym[SymW-1:0]} << cnt_q;
	assign enc_buf  = buf_q | enc_ins[BufW-1:0];
	assign dec_buf  = buf_q | dec_ins[BufW-1:0];
	assign enc_sum  = {1'b0, cnt_q} + 5'd8;
	assign dec_sum  = {1'b0, cnt_q} + 5'd5;
	assign enc_two  = (enc_sum >= 5'd10);
	assign enc_rem  = enc_two ? (enc_sum - 5'd10) : (enc_sum - 5'd5);
	assign enc_left = enc_two ? (enc_buf >> 10) : (enc_buf >> 5);

	always_comb begin
		job      = '0;
		job_push = 1'b0;
		nxt_buf  = buf_q;
		nxt_cnt  = cnt_q;
		job.eos  = end_of_stream;
		if (direction_q == DirEncode) begin
			job.vals[0] = sym_to_char(enc_buf[4:0]);
			job.vals[1] = sym_to_char(enc_buf[9:5]);
			job.vals[2] = sym_to_char({3'b000, enc_buf[11:10]});
			job.num     = {1'b0, 1'b1} + {1'b0, enc_two}
			            + {1'b0, end_of_stream && (enc_rem != 5'd0)};
			job_push    = in_valid;
			nxt_buf     = enc_left;
			nxt_cnt     = enc_rem[CntW-1:0];
		end else begin
			job.vals[0] = dec_buf[7:0];
			job.num     = 2'd1;
			job.bad     = dec_sym[SymW];
			job_push    = in_valid && (dec_sum >= 5'd8);
			if (dec_sum >= 5'd8) begin
				nxt_buf = dec_buf >> 8;
				nxt_cnt = CntW'(dec_sum - 5'd8);
			end else begin
				nxt_buf = dec_buf;
				nxt_cnt = dec_sum[CntW-1:0];
			end
		end
		if (end_of_stream) begin
			nxt_buf = '0;
			nxt_cnt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DirEncode;
			buf_q       <= '0;
			cnt_q       <= '0;
		end else if (cfg_we) begin
			direction_q <= cfg_wdata;
			buf_q       <= '0;
			cnt_q       <= '0;
		end else if (in_valid) begin
			buf_q <= nxt_buf;
			cnt_q <= nxt_cnt;
		end
	end

endmodule

### src/b32sc_fifo.sv
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps
module b32sc_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  b32sc_pkg::job_t  wr_data,
	output logic             q_full,
	input  logic             rd_en,
	output b32sc_pkg::job_t  rd_data,
	output logic             q_empty
);
	import b32sc_pkg::*;

	job_t             mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] fill_q;

	assign q_full  = (fill_q == QCntW'(QDepth));
	assign q_empty = (fill_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				fill_q <= fill_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

### src/b32sc_back.sv
// Back end: plays each job out one word at a time into the result register.
`timescale 1ns / 1ps
module b32sc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  b32sc_pkg::job_t               job,
	input  logic                          job_empty,
	output logic                          job_pop,
	output logic                          empty,
	input  logic                          pop,
	output logic [b32sc_pkg::DataW-1:0]   data_out,
	output logic                          run_last,
	output logic                          stream_end,
	output logic                          bad_symbol
);
	import b32sc_pkg::*;

	logic             out_valid_q;
	logic [DataW-1:0] data_q;
	logic             last_q;
	logic             end_q;
	logic             bad_q;
	logic [1:0]       idx_q;

	logic             load;
	logic             take;
	logic             is_last;
	logic [DataW-1:0] cur_val;

	assign load    = !out_valid_q || pop;
	assign take    = load && !job_empty;
	assign is_last = ((idx_q + 2'd1) == job.num);
	assign job_pop = take && is_last;

	always_comb begin
		case (idx_q)
			2'd0:    cur_val = job.vals[0];
			2'd1:    cur_val = job.vals[1];
			2'd2:    cur_val = job.vals[2];
			default: cur_val = job.vals[0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= !job_empty;
			if (take) begin
				idx_q <= is_last ? 2'd0 : (idx_q + 2'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_q <= cur_val;
			last_q <= is_last;
			end_q  <= is_last && job.eos;
			bad_q  <= job.bad;
		end
	end

	assign empty      = !out_valid_q;
	assign data_out   = data_q;
	assign run_last   = last_q;
	assign stream_end = end_q;
	assign bad_symbol = bad_q;

endmodule

### src/base32_stream_codec.sv
// Top level of the streaming Base32 codec (A-Z, 2-7, LSB-first packing, no padding).
// The first result word of an input word passes through the job queue and then the result
//   register before it shows on the result side.
// Throughput: one input word per cycle while the queue has room, and one result word
//   per cycle unless the result side stalls; encoding yields up to three words per byte.
// Reset (arst_n low): direction returns to encode, the accumulator clears, queue and result register empty.
`timescale 1ns / 1ps
module base32_stream_codec (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration: direction register
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	// input side
	input  logic                          push,
	output logic                          full,
	input  logic [b32sc_pkg::DataW-1:0]   data_in,
	input  logic                          end_of_stream,
	// result side
	output logic                          empty,
	input  logic                          pop,
	output logic [b32sc_pkg::DataW-1:0]   data_out,
	output logic                          run_last,
	output logic                          stream_end,
	output logic                          bad_symbol
);
	import b32sc_pkg::*;

	logic  in_valid;
	logic  job_push;
	job_t  front_job;
	job_t  queue_job;
	logic  queue_full;
	logic  queue_empty;
	logic  job_pop;

	// Take an input word whenever the job queue has room; the accumulator update is
	// done in the same cycle so the next word can follow right away.
	assign full     = queue_full;
	assign in_valid = push && !queue_full;

	// Front: classify the word, update the accumulator, and build a job holding every
	// result word it causes. Words that cause no result push nothing.
	b32sc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.data_in       (data_in),
		.end_of_stream (end_of_stream),
		.job_push      (job_push),
		.job           (front_job)
	);

	// Queue: decouple the front from result-side stalls.
	b32sc_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_data (front_job),
		.q_full  (queue_full),
		.rd_en   (job_pop),
		.rd_data (queue_job),
		.q_empty (queue_empty)
	);

	// Back: advance through the head job one word per cycle while the result register is
	// free or popped, and drop the job from the queue once its last word is loaded.
	b32sc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (queue_job),
		.job_empty  (queue_empty),
		.job_pop    (job_pop),
		.empty      (empty),
		.pop        (pop),
		.data_out   (data_out),
		.run_last   (run_last),
		.stream_end (stream_end),
		.bad_symbol (bad_symbol)
	);

endmodule
